FILE: sv/nqsc_pkg.sv
// Shared types and constants of the N-queens solution counter.
`default_nettype none

package nqsc_pkg;

  // Width of the board size register and of the solution count.
  localparam int unsigned BoardSizeW = 5;
  localparam int unsigned CountW     = 63;

  // Board size after reset.
  localparam logic [BoardSizeW-1:0] BoardSizeReset = 5'd8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;         // Start a run: free all masks, row one, column one, count zero.
    logic step;         // Try the current column of the current row.
    logic pop;          // Go back one row and fetch the column chosen there.
    logic restore;      // Free the fetched column and move past it.
    logic load_result;  // Copy the count into the output register.
  } nqsc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic n_zero;      // Saturated board size is zero.
    logic col_gt_n;    // All columns of the current row have been tried.
    logic row_le_one;  // The search stands on the first row.
  } nqsc_status_t;

endpackage

`default_nettype wire

FILE: sv/nqsc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nqsc_ram #(
  parameter int unsigned Width = 5,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/nqsc_dpath.sv
// Datapath of the N-queens counter: occupancy masks, row and column, choice stack, count.
`default_nettype none

module nqsc_dpath import nqsc_pkg::*; #(
  parameter int unsigned MaxBoard = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  board_size_we_i,
  input  wire logic [BoardSizeW-1:0] board_size_i,
  input  wire nqsc_cmd_t             cmd_i,
  output nqsc_status_t               status_o,
  output logic      [CountW-1:0]     solution_count_o
);

  // Row values reach N and column values N + 1; diagonal indexes reach 2N - 2.
  localparam int unsigned RW = $clog2(MaxBoard + 2);
  localparam int unsigned DW = 2 * MaxBoard - 1;
  localparam int unsigned SW = $clog2(2 * MaxBoard + 1);
  localparam int unsigned AW = (MaxBoard > 1) ? $clog2(MaxBoard) : 1;
  localparam logic [BoardSizeW-1:0] MaxBoardSz = BoardSizeW'(MaxBoard);

  logic [BoardSizeW-1:0] board_size_q;
  logic [RW-1:0]         n_sat;
  logic [RW-1:0]         n_q;
  logic [RW-1:0]         row_q, row_d;
  logic [RW-1:0]         col_q, col_d;
  logic [MaxBoard-1:0]   colf_q, colf_d;
  logic [DW-1:0]         adf_q, adf_d;
  logic [DW-1:0]         dgf_q, dgf_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [CountW-1:0]     result_q;

  logic [RW-1:0]         sel_col;
  logic [RW-1:0]         col_m1;
  logic [RW-1:0]         row_m1;
  logic [RW-1:0]         row_m2;
  logic [SW-1:0]         ad_idx;
  logic [SW-1:0]         dg_idx;
  logic [MaxBoard-1:0]   col_bit;
  logic [DW-1:0]         ad_bit;
  logic [DW-1:0]         dg_bit;
  logic                  col_gt_n;
  logic                  is_free;
  logic                  ram_we;
  logic [RW-1:0]         ram_rdata;

  // Board size register, written from the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      board_size_q <= BoardSizeReset;
    end else if (board_size_we_i) begin
      board_size_q <= board_size_i;
    end
  end

  // Sizes above the board limit saturate.
  assign n_sat = (board_size_q > MaxBoardSz) ? RW'(MaxBoard) : RW'(board_size_q);

  // During a restore the column comes from the choice stack, otherwise from the column register.
  assign sel_col = cmd_i.restore ? ram_rdata : col_q;
  assign col_m1  = sel_col - RW'(1);
  assign row_m1  = row_q - RW'(1);
  assign row_m2  = row_q - RW'(2);
  assign ad_idx  = SW'(row_q) + SW'(sel_col) - SW'(2);
  assign dg_idx  = SW'(row_q) + SW'(n_q) - SW'(sel_col) - SW'(1);

  // One-hot masks of the column and both diagonals through the square.
  assign col_bit = MaxBoard'(1) << col_m1;
  assign ad_bit  = DW'(1) << ad_idx;
  assign dg_bit  = DW'(1) << dg_idx;

  assign col_gt_n = (col_q > n_q);
  assign is_free  = (|(colf_q & col_bit)) && (|(adf_q & ad_bit)) && (|(dgf_q & dg_bit));

  // A free square is recorded on the choice stack.
  assign ram_we = cmd_i.step && !col_gt_n && is_free;

  // Search step: init, place, count, advance, pop or restore.
  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    colf_d  = colf_q;
    adf_d   = adf_q;
    dgf_d   = dgf_q;
    count_d = count_q;
    if (cmd_i.init) begin
      row_d   = RW'(1);
      col_d   = RW'(1);
      colf_d  = '1;
      adf_d   = '1;
      dgf_d   = '1;
      count_d = '0;
    end else if (cmd_i.step && !col_gt_n) begin
      if (is_free && (row_q < n_q)) begin
        colf_d = colf_q & ~col_bit;
        adf_d  = adf_q & ~ad_bit;
        dgf_d  = dgf_q & ~dg_bit;
        row_d  = row_q + RW'(1);
        col_d  = RW'(1);
      end else begin
        if (is_free) begin
          count_d = count_q + CountW'(1);
        end
        col_d = col_q + RW'(1);
      end
    end else if (cmd_i.pop) begin
      row_d = row_m1;
    end else if (cmd_i.restore) begin
      colf_d = colf_q | col_bit;
      adf_d  = adf_q | ad_bit;
      dgf_d  = dgf_q | dg_bit;
      col_d  = ram_rdata + RW'(1);
    end
  end

  // Search control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= RW'(1);
      col_q   <= RW'(1);
      n_q     <= '0;
      colf_q  <= '1;
      adf_q   <= '1;
      dgf_q   <= '1;
      count_q <= '0;
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      colf_q  <= colf_d;
      adf_q   <= adf_d;
      dgf_q   <= dgf_d;
      count_q <= count_d;
      if (cmd_i.init) begin
        n_q <= n_sat;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      result_q <= count_q;
    end
  end

  // Stack of the column chosen in each row.
  nqsc_ram #(
    .Width (RW),
    .Depth (MaxBoard),
    .AddrW (AW)
  ) u_choice_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (row_m1[AW-1:0]),
    .wdata_i (col_q),
    .re_i    (cmd_i.pop),
    .raddr_i (row_m2[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign status_o.n_zero     = (n_sat == '0);
  assign status_o.col_gt_n   = col_gt_n;
  assign status_o.row_le_one = (row_q <= RW'(1));
  assign solution_count_o    = result_q;

  // The search row always lies on the board while columns are tried.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (row_q >= RW'(1)) && (row_q <= n_q))
    else $error("search row left the board");

  // One column is taken for each row above the current one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> ($countones(~colf_q) == int'(row_q) - 1))
    else $error("column mask disagrees with the search depth");

endmodule

`default_nettype wire

FILE: sv/nqsc_ctrl.sv
// Controller of the N-queens counter: run sequencing and the handshakes.
`default_nettype none

module nqsc_ctrl import nqsc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire logic         start_req_i,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire nqsc_status_t status_i,
  output nqsc_cmd_t         cmd_o
);

  typedef enum logic [3:0] {
    StIdle    = 4'b0001,
    StCheck   = 4'b0010,
    StRestore = 4'b0100,
    StFinish  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_accept;

  assign in_ready_o = (state_q == StIdle);
  assign in_accept  = in_valid_i && in_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_accept && start_req_i) begin
          cmd_o.init = 1'b1;
          state_d    = status_i.n_zero ? StFinish : StCheck;
        end
      end
      StCheck: begin
        if (!status_i.col_gt_n) begin
          cmd_o.step = 1'b1;
        end else if (status_i.row_le_one) begin
          state_d = StFinish;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = StRestore;
        end
      end
      StRestore: begin
        cmd_o.restore = 1'b1;
        state_d       = StCheck;
      end
      StFinish: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // The output word stays valid until it is taken or replaced.
  always_comb begin
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // At most one datapath command is issued per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.init, cmd_o.step, cmd_o.pop, cmd_o.restore, cmd_o.load_result}))
    else $error("more than one datapath command at once");

  // A start request always begins a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && start_req_i) |=> (state_q != StIdle))
    else $error("start request did not begin a run");

endmodule

`default_nettype wire

FILE: sv/n_queens_solution_counter.sv
// Top level of the N-queens solution counter.
//
// Each accepted word with start_req_i set runs a depth-first backtracking
// search over the board size held in the board size register (sizes above
// MAX_BOARD are treated as MAX_BOARD) and returns one word, the number of
// solutions; a word with start_req_i clear is taken and gives nothing. A run
// starts with the init command, tries each column in a single check-and-place
// step, steps back to an earlier row through a pop and a restore, and finishes
// with the last check and the output load, which waits while an earlier count
// is still held at the output, so its length follows the size of the search
// tree. Each step back goes through the registered read of the column stack.
// One run is in flight at a time; input is taken only between runs, while the
// previous count may still wait at the output. Size zero skips the search and
// gives a count of zero. The board size is sampled when a run starts.
`default_nettype none

module n_queens_solution_counter import nqsc_pkg::*; #(
  parameter int unsigned MAX_BOARD = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  board_size_we_i,
  input  wire logic [BoardSizeW-1:0] board_size_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  start_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic      [CountW-1:0]     solution_count_o
);

  nqsc_cmd_t    cmd;
  nqsc_status_t status;

  // Run sequencing and handshakes.
  nqsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .start_req_i (start_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Search state and count.
  nqsc_dpath #(
    .MaxBoard (MAX_BOARD)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .board_size_we_i  (board_size_we_i),
    .board_size_i     (board_size_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .solution_count_o (solution_count_o)
  );

endmodule

`default_nettype wire
